FILE: rtl/lcd_dot_mode_timing_core_macros.svh
// ----------------------------------------------------------------------------
// LCD dot/mode timing core: assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCD_DOT_MODE_TIMING_CORE_MACROS_SVH
`define LCD_DOT_MODE_TIMING_CORE_MACROS_SVH

// same-cycle implication
`define LDMT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LDMT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lcd_dmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD dot/mode timing package
// Types, register indexes and timing constants shared by the core.
// ----------------------------------------------------------------------------
package lcd_dmt_pkg;

    // default geometry
    localparam int unsigned DOTS_PER_LINE_DEF = 456;
    localparam int unsigned VISIBLE_LINES_DEF = 144;
    localparam int unsigned TOTAL_LINES_DEF   = 154;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAT_EN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd6;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam int unsigned LCDC_DISPLAY_BIT = 7;
    localparam int unsigned LCDC_WINDOW_BIT  = 5;

    localparam int unsigned STAT_EN_HBLANK = 0;
    localparam int unsigned STAT_EN_VBLANK = 1;
    localparam int unsigned STAT_EN_OAM    = 2;
    localparam int unsigned STAT_EN_LYC    = 3;

    localparam logic [8:0]  OAM_END_DOT  = 9'd80;
    localparam logic [8:0]  XFER_END_DOT = 9'd252;
    localparam logic [15:0] OAM_BASE     = 16'hFE00;
    localparam logic [7:0]  WX_LIMIT     = 8'd166;
    localparam logic [7:0]  VBLANK_LINE  = 8'd144;
    localparam logic [5:0]  OAM_LAST_PAIR = 6'd39;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [3:0] stat_en;
        logic [7:0] line_cmp;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
    } lcd_dmt_cfg_t;

    typedef struct packed {
        logic [8:0]  dot;
        logic [7:0]  line;
        lcd_mode_t   mode;
        logic        coin;
        logic [7:0]  win_line;
        logic [15:0] scan_addr;
        logic [15:0] frozen_addr;
        logic [7:0]  scx;
        logic [7:0]  scy;
    } lcd_dmt_state_t;

    typedef struct packed {
        logic vblank;
        logic stat;
        logic xfer;
    } lcd_dmt_pulse_t;

endpackage
`default_nettype wire

FILE: rtl/lcd_dmt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD dot/mode timing channels
// Valid/ready channels for dot ticks, timing results and register writes.
// ----------------------------------------------------------------------------
interface lcd_dmt_in_if;
    logic valid;
    logic ready;
    logic dot_tick;

    modport source (output valid, output dot_tick, input ready);
    modport sink   (input valid, input dot_tick, output ready);
endinterface

interface lcd_dmt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  lcd_mode;
    logic [7:0]  line_now;
    logic [8:0]  dot_now;
    logic        coincidence;
    logic        vblank_irq;
    logic        stat_irq;
    logic [7:0]  window_line;
    logic [15:0] oam_pair_address;
    logic [15:0] oam_frozen_address;
    logic        transfer_start;
    logic [7:0]  latched_scroll_x;
    logic [7:0]  latched_scroll_y;

    modport source (output valid, output lcd_mode, output line_now, output dot_now,
                    output coincidence, output vblank_irq, output stat_irq,
                    output window_line, output oam_pair_address,
                    output oam_frozen_address, output transfer_start,
                    output latched_scroll_x, output latched_scroll_y, input ready);
    modport sink   (input valid, input lcd_mode, input line_now, input dot_now,
                    input coincidence, input vblank_irq, input stat_irq,
                    input window_line, input oam_pair_address,
                    input oam_frozen_address, input transfer_start,
                    input latched_scroll_x, input latched_scroll_y, output ready);
endinterface

interface lcd_dmt_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lcd_dmt_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD dot/mode timing register file
// Holds LCDC, STAT enables, LYC, window and scroll registers.
// ----------------------------------------------------------------------------
module lcd_dmt_regs (
    input  wire                    clk,
    input  wire                    rst_n,
    lcd_dmt_cfg_if.sink            cfg,
    output lcd_dmt_pkg::lcd_dmt_cfg_t regs
);
    import lcd_dmt_pkg::*;

    lcd_dmt_cfg_t regs_reg;

    // writes are taken every cycle
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{lcd_control: LCDC_RESET,
                          stat_en:     4'd0,
                          line_cmp:    8'd0,
                          window_y:    8'd0,
                          window_x:    8'd0,
                          scroll_x:    8'd0,
                          scroll_y:    8'd0};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LCD_CONTROL: regs_reg.lcd_control <= cfg.data;
                CFG_STAT_EN:     regs_reg.stat_en     <= cfg.data[3:0];
                CFG_LINE_CMP:    regs_reg.line_cmp    <= cfg.data;
                CFG_WINDOW_Y:    regs_reg.window_y    <= cfg.data;
                CFG_WINDOW_X:    regs_reg.window_x    <= cfg.data;
                CFG_SCROLL_X:    regs_reg.scroll_x    <= cfg.data;
                CFG_SCROLL_Y:    regs_reg.scroll_y    <= cfg.data;
                default:         ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lcd_dmt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD dot/mode timing step
// Next dot, line, mode, window line and OAM scan state for one tick.
// ----------------------------------------------------------------------------
module lcd_dmt_step #(
    parameter int unsigned DOTS_PER_LINE = lcd_dmt_pkg::DOTS_PER_LINE_DEF,
    parameter int unsigned VISIBLE_LINES = lcd_dmt_pkg::VISIBLE_LINES_DEF,
    parameter int unsigned TOTAL_LINES   = lcd_dmt_pkg::TOTAL_LINES_DEF
) (
    input  wire                         dot_tick,
    input  lcd_dmt_pkg::lcd_dmt_cfg_t   regs,
    input  lcd_dmt_pkg::lcd_dmt_state_t state_cur,
    output lcd_dmt_pkg::lcd_dmt_state_t state_next,
    output lcd_dmt_pkg::lcd_dmt_pulse_t pulse_next
);
    import lcd_dmt_pkg::*;

    logic       run;
    lcd_mode_t  mode_sel;
    logic       mode_chg;
    logic [9:0] dot_inc;
    logic       line_end;
    logic [7:0] line_inc;
    logic       line_wrap;
    logic       coin_hit;
    logic       win_adv;
    logic [5:0] pair_idx;

    assign run = dot_tick && regs.lcd_control[LCDC_DISPLAY_BIT];

    always_comb
    begin
        if (state_cur.line >= 8'(VISIBLE_LINES))
            mode_sel = MODE_VBLANK;
        else if (state_cur.dot < OAM_END_DOT)
            mode_sel = MODE_OAM;
        else if (state_cur.dot < XFER_END_DOT)
            mode_sel = MODE_XFER;
        else
            mode_sel = MODE_HBLANK;
    end

    assign mode_chg  = run && (mode_sel != state_cur.mode);
    assign dot_inc   = {1'b0, state_cur.dot} + 10'd1;
    assign line_end  = (dot_inc >= 10'(DOTS_PER_LINE)) || (dot_inc[8:0] == 9'd0);
    assign line_inc  = state_cur.line + 8'd1;
    assign line_wrap = line_end && (line_inc == 8'(TOTAL_LINES));
    assign coin_hit  = (line_inc == regs.line_cmp);
    assign win_adv   = regs.lcd_control[LCDC_WINDOW_BIT]
                       && (state_cur.line < 8'(VISIBLE_LINES))
                       && (state_cur.line >= regs.window_y)
                       && (regs.window_x <= WX_LIMIT);
    assign pair_idx  = (state_cur.dot < OAM_END_DOT) ? state_cur.dot[6:1] : OAM_LAST_PAIR;

    // next state
    always_comb
    begin
        state_next = state_cur;
        if (dot_tick && !regs.lcd_control[LCDC_DISPLAY_BIT])
        begin
            state_next.line = 8'd0;
            state_next.mode = MODE_HBLANK;
        end
        else if (run)
        begin
            state_next.mode = mode_sel;
            if (mode_chg && (mode_sel == MODE_XFER))
            begin
                state_next.scx         = regs.scroll_x;
                state_next.scy         = regs.scroll_y;
                state_next.frozen_addr = state_cur.scan_addr;
            end

            if (mode_sel == MODE_OAM)
                state_next.scan_addr = OAM_BASE + {8'd0, pair_idx, 2'b00};
            else if (mode_sel != MODE_XFER)
                state_next.scan_addr = OAM_BASE;

            if (line_end)
            begin
                state_next.dot  = 9'd0;
                state_next.line = line_inc;
                state_next.coin = coin_hit;
                if (win_adv)
                    state_next.win_line = state_cur.win_line + 8'd1;
                if (line_wrap)
                begin
                    state_next.line     = 8'd0;
                    state_next.mode     = MODE_OAM;
                    state_next.win_line = 8'd0;
                end
            end
            else
            begin
                state_next.dot = dot_inc[8:0];
            end
        end
    end

    // interrupt and transfer pulses
    always_comb
    begin
        pulse_next = '0;
        if (mode_chg)
        begin
            unique case (mode_sel)
                MODE_OAM:    pulse_next.stat = regs.stat_en[STAT_EN_OAM];
                MODE_XFER:   pulse_next.xfer = 1'b1;
                MODE_HBLANK: pulse_next.stat = regs.stat_en[STAT_EN_HBLANK];
                MODE_VBLANK:
                begin
                    if (state_cur.line == VBLANK_LINE)
                    begin
                        pulse_next.vblank = 1'b1;
                        pulse_next.stat   = regs.stat_en[STAT_EN_VBLANK];
                    end
                end
                default: ;
            endcase
        end
        if (run && line_end)
        begin
            if (coin_hit && regs.stat_en[STAT_EN_LYC])
                pulse_next.stat = 1'b1;
            if (line_wrap && regs.stat_en[STAT_EN_OAM])
                pulse_next.stat = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lcd_dot_mode_timing_core.sv
// An accepted tick's result word is registered and shown in the next cycle.
// Throughput: one tick per cycle while the result is taken; the next-state logic is a single pass
// between the timing state registers and the result register.
// A full result register still accepts a tick when the result is taken that cycle.
// Reset (rst_n low, async): dot 0, line 0, mode HBlank, addresses 0xFE00,
// LCDC 0x91, other registers 0, no result pending.
`default_nettype none
// ----------------------------------------------------------------------------
// LCD dot/mode timing core
// Dot, line and mode sequencer with STAT/VBlank pulses and transfer latches.
// ----------------------------------------------------------------------------
`include "lcd_dot_mode_timing_core_macros.svh"

module lcd_dot_mode_timing_core #(
    parameter int unsigned DOTS_PER_LINE = lcd_dmt_pkg::DOTS_PER_LINE_DEF,
    parameter int unsigned VISIBLE_LINES = lcd_dmt_pkg::VISIBLE_LINES_DEF,
    parameter int unsigned TOTAL_LINES   = lcd_dmt_pkg::TOTAL_LINES_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    lcd_dmt_in_if.sink     tick,
    lcd_dmt_out_if.source  result,
    lcd_dmt_cfg_if.sink    cfg
);
    import lcd_dmt_pkg::*;

    lcd_dmt_cfg_t   regs;
    lcd_dmt_state_t state_reg;
    lcd_dmt_state_t state_next;
    lcd_dmt_pulse_t pulse_reg;
    lcd_dmt_pulse_t pulse_next;
    logic           out_valid_reg;
    logic           accept;

    lcd_dmt_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lcd_dmt_step #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_step (
        .dot_tick   (tick.dot_tick),
        .regs       (regs),
        .state_cur  (state_reg),
        .state_next (state_next),
        .pulse_next (pulse_next)
    );

    // take a word whenever the result slot is empty or draining
    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{dot:         9'd0,
                               line:        8'd0,
                               mode:        MODE_HBLANK,
                               coin:        1'b0,
                               win_line:    8'd0,
                               scan_addr:   OAM_BASE,
                               frozen_addr: OAM_BASE,
                               scx:         8'd0,
                               scy:         8'd0};
            pulse_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            pulse_reg     <= pulse_next;
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // the timing state doubles as the result payload
    assign result.valid              = out_valid_reg;
    assign result.lcd_mode           = state_reg.mode;
    assign result.line_now           = state_reg.line;
    assign result.dot_now            = state_reg.dot;
    assign result.coincidence        = state_reg.coin;
    assign result.vblank_irq         = pulse_reg.vblank;
    assign result.stat_irq           = pulse_reg.stat;
    assign result.window_line        = state_reg.win_line;
    assign result.oam_pair_address   = state_reg.scan_addr;
    assign result.oam_frozen_address = state_reg.frozen_addr;
    assign result.transfer_start     = pulse_reg.xfer;
    assign result.latched_scroll_x   = state_reg.scx;
    assign result.latched_scroll_y   = state_reg.scy;

    `LDMT_ASSERT_NXT(a_accept_gives_word, accept, out_valid_reg, "accepted tick lost its word")
    `LDMT_ASSERT_IMP(a_xfer_in_mode3, out_valid_reg && pulse_reg.xfer, state_reg.mode == MODE_XFER, "transfer pulse outside mode 3")
    `LDMT_ASSERT_IMP(a_vblank_in_mode1, out_valid_reg && pulse_reg.vblank, state_reg.mode == MODE_VBLANK, "VBlank pulse outside mode 1")
    `LDMT_ASSERT_IMP(a_dot_in_range, 1'b1, state_reg.dot < 9'(DOTS_PER_LINE) || DOTS_PER_LINE >= 512, "dot counter past line end")

endmodule
`default_nettype wire

FILE: tb/sv/lcd_dmt_tb_pkg.sv
// ----------------------------------------------------------------------------
// LCD dot/mode timing scoreboard
// Predicts each timing word from the accepted dot ticks and register writes,
// and compares the words coming out of the core, field by field, in order.
// ----------------------------------------------------------------------------
package lcd_dmt_tb_pkg;
    import lcd_dmt_pkg::*;

    // index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int unsigned MAX_REPORTS = 40;

    typedef enum int {
        PACE_FULL,
        PACE_SLOW_SOURCE,
        PACE_SLOW_SINK,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        lcd_mode_t   mode;
        logic [7:0]  line;
        logic [8:0]  dot;
        logic        coin;
        logic        vblank;
        logic        stat;
        logic [7:0]  win_line;
        logic [15:0] scan_addr;
        logic [15:0] frozen_addr;
        logic        xfer;
        logic [7:0]  scx;
        logic [7:0]  scy;
    } timing_word_t;

    class lcd_timing_scoreboard;
        // register file
        logic [7:0]  lcdc;
        logic [3:0]  stat_en;
        logic [7:0]  lyc;
        logic [7:0]  wy;
        logic [7:0]  wx;
        logic [7:0]  scroll_x;
        logic [7:0]  scroll_y;
        // timing state
        logic [8:0]  dot;
        logic [7:0]  line;
        lcd_mode_t   mode;
        logic        coin;
        logic [7:0]  win_line;
        logic [15:0] scan_addr;
        logic [15:0] frozen_addr;
        logic [7:0]  scx_snap;
        logic [7:0]  scy_snap;

        timing_word_t expected_words[$];

        int unsigned errors;
        int unsigned ticks;
        int unsigned idle_ticks;
        int unsigned dark_ticks;
        int unsigned words_checked;
        int unsigned vblank_pulses;
        int unsigned stat_pulses;
        int unsigned xfer_pulses;
        int unsigned frame_wraps;
        int unsigned lyc_matches;

        function new();
            lcdc        = LCDC_RESET;
            stat_en     = '0;
            lyc         = '0;
            wy          = '0;
            wx          = '0;
            scroll_x    = '0;
            scroll_y    = '0;
            dot         = '0;
            line        = '0;
            mode        = MODE_HBLANK;
            coin        = 1'b0;
            win_line    = '0;
            scan_addr   = OAM_BASE;
            frozen_addr = OAM_BASE;
            scx_snap    = '0;
            scy_snap    = '0;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LCD_CONTROL: lcdc     = data;
                CFG_STAT_EN:     stat_en  = data[3:0];
                CFG_LINE_CMP:    lyc      = data;
                CFG_WINDOW_Y:    wy       = data;
                CFG_WINDOW_X:    wx       = data;
                CFG_SCROLL_X:    scroll_x = data;
                CFG_SCROLL_Y:    scroll_y = data;
                default: ;
            endcase
        endfunction

        // advance the timing state by one accepted tick and queue the word it yields
        function void note_tick(logic tick);
            timing_word_t w;
            lcd_mode_t    next_mode;
            logic [7:0]   prev_line;
            logic [5:0]   pair;

            w = '0;
            ticks++;
            if (!tick)
                idle_ticks++;
            else if (!lcdc[LCDC_DISPLAY_BIT]) begin
                // display off: pin line and mode, hold everything else
                dark_ticks++;
                line = '0;
                mode = MODE_HBLANK;
            end
            else begin
                if (line >= VISIBLE_LINES_DEF)
                    next_mode = MODE_VBLANK;
                else if (dot < OAM_END_DOT)
                    next_mode = MODE_OAM;
                else if (dot < XFER_END_DOT)
                    next_mode = MODE_XFER;
                else
                    next_mode = MODE_HBLANK;

                if (next_mode != mode) begin
                    mode = next_mode;
                    case (next_mode)
                        MODE_OAM:    w.stat = stat_en[STAT_EN_OAM];
                        MODE_XFER:
                        begin
                            scx_snap    = scroll_x;
                            scy_snap    = scroll_y;
                            frozen_addr = scan_addr;
                            w.xfer      = 1'b1;
                        end
                        MODE_HBLANK: w.stat = stat_en[STAT_EN_HBLANK];
                        default:
                        begin
                            if (line == VBLANK_LINE) begin
                                w.vblank = 1'b1;
                                w.stat   = stat_en[STAT_EN_VBLANK];
                            end
                        end
                    endcase
                end

                if (mode == MODE_OAM) begin
                    pair      = (dot < OAM_END_DOT) ? dot[6:1] : OAM_LAST_PAIR;
                    scan_addr = OAM_BASE + {8'd0, pair, 2'b00};
                end
                else if (mode != MODE_XFER)
                    scan_addr = OAM_BASE;

                dot = dot + 9'd1;
                if (dot >= DOTS_PER_LINE_DEF || dot == 9'd0) begin
                    prev_line = line;
                    dot  = '0;
                    line = line + 8'd1;

                    if (lcdc[LCDC_WINDOW_BIT] && prev_line < VISIBLE_LINES_DEF &&
                        prev_line >= wy && wx <= WX_LIMIT)
                        win_line = win_line + 8'd1;

                    // compare before the frame wrap, so line 0 never matches here
                    if (line == lyc) begin
                        coin = 1'b1;
                        lyc_matches++;
                        if (stat_en[STAT_EN_LYC])
                            w.stat = 1'b1;
                    end
                    else
                        coin = 1'b0;

                    if (line == 8'(TOTAL_LINES_DEF)) begin
                        frame_wraps++;
                        line     = '0;
                        mode     = MODE_OAM;
                        win_line = '0;
                        if (stat_en[STAT_EN_OAM])
                            w.stat = 1'b1;
                    end
                end
            end

            w.mode        = mode;
            w.line        = line;
            w.dot         = dot;
            w.coin        = coin;
            w.win_line    = win_line;
            w.scan_addr   = scan_addr;
            w.frozen_addr = frozen_addr;
            w.scx         = scx_snap;
            w.scy         = scy_snap;
            vblank_pulses += w.vblank;
            stat_pulses   += w.stat;
            xfer_pulses   += w.xfer;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string tag, int unsigned want, int unsigned got,
                                    timing_word_t ref_word);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch at line %0d dot %0d: expected %0d, got %0d",
                             $time, tag, ref_word.line, ref_word.dot, want, got);
            end
        endfunction

        function void check_word(timing_word_t got);
            timing_word_t want;

            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, got line %0d dot %0d",
                             $time, got.line, got.dot);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            compare_field("lcd_mode", want.mode, got.mode, want);
            compare_field("line_now", want.line, got.line, want);
            compare_field("dot_now", want.dot, got.dot, want);
            compare_field("coincidence", want.coin, got.coin, want);
            compare_field("vblank_irq", want.vblank, got.vblank, want);
            compare_field("stat_irq", want.stat, got.stat, want);
            compare_field("window_line", want.win_line, got.win_line, want);
            compare_field("oam_pair_address", want.scan_addr, got.scan_addr, want);
            compare_field("oam_frozen_address", want.frozen_addr, got.frozen_addr, want);
            compare_field("transfer_start", want.xfer, got.xfer, want);
            compare_field("latched_scroll_x", want.scx, got.scx, want);
            compare_field("latched_scroll_y", want.scy, got.scy, want);
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_lcd_dot_mode_timing_core.sv
// ----------------------------------------------------------------------------
// LCD dot/mode timing core testbench
// Walks the first line past its end with register changes between bursts,
// then a noisy tail with random registers and display toggles.
// Source and sink idle at random per phase; every word is scoreboarded.
// ----------------------------------------------------------------------------
module tb_lcd_dot_mode_timing_core;
    import lcd_dmt_pkg::*;
    import lcd_dmt_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 60_000;
    localparam int unsigned NOISE_BURSTS = 2;
    localparam int unsigned NOISE_TICKS  = 10;

    logic clk = 1'b0;
    logic rst_n;
    int unsigned cycles_run = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    lcd_timing_scoreboard sb = new();

    lcd_dmt_in_if  tick_if ();
    lcd_dmt_out_if res_if ();
    lcd_dmt_cfg_if cfg_if ();

    lcd_dot_mode_timing_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // score every handshake on the edge where it happens: result first,
    // since a word never leaves on the edge that takes its tick
    always @(posedge clk)
    begin
        timing_word_t got;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.mode        = lcd_mode_t'(res_if.lcd_mode);
                got.line        = res_if.line_now;
                got.dot         = res_if.dot_now;
                got.coin        = res_if.coincidence;
                got.vblank      = res_if.vblank_irq;
                got.stat        = res_if.stat_irq;
                got.win_line    = res_if.window_line;
                got.scan_addr   = res_if.oam_pair_address;
                got.frozen_addr = res_if.oam_frozen_address;
                got.xfer        = res_if.transfer_start;
                got.scx         = res_if.latched_scroll_x;
                got.scy         = res_if.latched_scroll_y;
                sb.check_word(got);
            end
            if (tick_if.valid && tick_if.ready)
                sb.note_tick(tick_if.dot_tick);
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
        end
    end

    task automatic set_pace(pace_t p);
        case (p)
            PACE_SLOW_SOURCE: begin idle_pct = 70; stall_pct = 0;  end
            PACE_SLOW_SINK:   begin idle_pct = 0;  stall_pct = 70; end
            PACE_BOTH:        begin idle_pct = 27; stall_pct = 27; end
            default:          begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic send_tick(logic t);
        while ($urandom_range(0, 99) < idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid    <= 1'b1;
        tick_if.dot_tick <= t;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
    endtask

    // drop valid, let the last tick be scored, then hold until every word is back
    task automatic drain();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    task automatic release_cfg();
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] edgy_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // keep the display on, steer LYC toward upcoming lines and the frame-end value
    task automatic retune_walk();
        logic [7:0] lcdc_v;
        logic [7:0] lyc_v;
        logic [7:0] wx_v;
        logic [7:0] wy_v;
        logic [3:0] stat_v;

        lcdc_v = 8'($urandom_range(0, 255));
        lcdc_v[LCDC_DISPLAY_BIT] = 1'b1;
        if ($urandom_range(0, 3) != 0)
            lcdc_v[LCDC_WINDOW_BIT] = 1'b1;

        if (sb.line >= 8'd148)
            lyc_v = 8'(TOTAL_LINES_DEF);
        else if ($urandom_range(0, 1) == 1)
            lyc_v = sb.line + 8'($urandom_range(0, 3));
        else
            lyc_v = edgy_byte();

        case ($urandom_range(0, 4))
            0:       wx_v = WX_LIMIT;
            1:       wx_v = WX_LIMIT + 8'd1;
            2:       wx_v = 8'h00;
            3:       wx_v = 8'hFF;
            default: wx_v = 8'($urandom_range(0, 255));
        endcase

        case ($urandom_range(0, 9))
            0:       wy_v = 8'hFF;
            1:       wy_v = 8'h00;
            default: wy_v = 8'($urandom_range(0, 150));
        endcase

        case ($urandom_range(0, 3))
            0:       stat_v = 4'h0;
            1:       stat_v = 4'hF;
            default: stat_v = 4'($urandom_range(0, 15));
        endcase

        write_cfg(CFG_LCD_CONTROL, lcdc_v);
        write_cfg(CFG_STAT_EN, {4'h0, stat_v});
        write_cfg(CFG_LINE_CMP, lyc_v);
        write_cfg(CFG_WINDOW_Y, wy_v);
        write_cfg(CFG_WINDOW_X, wx_v);
        write_cfg(CFG_SCROLL_X, edgy_byte());
        write_cfg(CFG_SCROLL_Y, edgy_byte());
        release_cfg();
    endtask

    // anything goes, display bit included; the unused index gets hit too
    task automatic scramble_regs();
        write_cfg(CFG_LCD_CONTROL, edgy_byte());
        write_cfg(CFG_STAT_EN, edgy_byte());
        write_cfg(CFG_LINE_CMP, edgy_byte());
        write_cfg(CFG_WINDOW_Y, edgy_byte());
        write_cfg(CFG_WINDOW_X, edgy_byte());
        write_cfg(CFG_SCROLL_X, edgy_byte());
        write_cfg(CFG_SCROLL_Y, edgy_byte());
        write_cfg(CFG_UNUSED, edgy_byte());
        release_cfg();
    endtask

    initial
    begin
        int unsigned burst;
        int unsigned n;

        rst_n            <= 1'b0;
        tick_if.valid    <= 1'b0;
        tick_if.dot_tick <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_LCD_CONTROL;
        cfg_if.data      <= '0;
        set_pace(PACE_FULL);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, idle tick, first dots with all STAT sources enabled
        send_tick(1'b0);
        drain();
        write_cfg(CFG_STAT_EN, 8'h0F);
        write_cfg(CFG_UNUSED, 8'hFF);
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // display off: line and mode pinned, dot held, no pulses
        write_cfg(CFG_LCD_CONTROL, 8'h00);
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // every register at its top value, display back on
        write_cfg(CFG_LCD_CONTROL, 8'hFF);
        write_cfg(CFG_STAT_EN, 8'hFF);
        write_cfg(CFG_LINE_CMP, 8'hFF);
        write_cfg(CFG_WINDOW_Y, 8'hFF);
        write_cfg(CFG_WINDOW_X, 8'hFF);
        write_cfg(CFG_SCROLL_X, 8'hFF);
        write_cfg(CFG_SCROLL_Y, 8'hFF);
        release_cfg();
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        // line walk: bursts of mostly live ticks until the first line has ended
        burst = 0;
        while (sb.line == 8'd0 || sb.dot < 9'd16) begin
            set_pace(pace_t'(burst % 4));
            retune_walk();
            n = $urandom_range(40, 80);
            repeat (n)
                send_tick($urandom_range(0, 19) != 0);
            drain();
            burst++;
        end

        // noisy tail under each pacing
        for (int p = 0; p < 4; p++) begin
            set_pace(pace_t'(p));
            for (int b = 0; b < NOISE_BURSTS; b++) begin
                drain();
                scramble_regs();
                repeat (NOISE_TICKS)
                    send_tick($urandom_range(0, 1) != 0);
            end
        end

        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d dot words (%0d idle, %0d display off), %0d frame wrap(s)",
                 sb.words_checked, sb.idle_ticks, sb.dark_ticks, sb.frame_wraps);
        $display("pulses: %0d vblank, %0d stat, %0d transfer start; %0d LY=LYC matches",
                 sb.vblank_pulses, sb.stat_pulses, sb.xfer_pulses, sb.lyc_matches);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: lcd_dot_mode_timing_core.f
+incdir+rtl
rtl/lcd_dmt_pkg.sv
rtl/lcd_dmt_if.sv
rtl/lcd_dmt_regs.sv
rtl/lcd_dmt_step.sv
rtl/lcd_dot_mode_timing_core.sv
tb/sv/lcd_dmt_tb_pkg.sv
tb/sv/tb_lcd_dot_mode_timing_core.sv
